FILE: rtl/core/kict_pkg.sv
// Package for the keyed item count table: request and result payload types,
// table command types, request and status codes, sequencer states.
// No dependencies.
package kict_pkg;

  // Table geometry
  localparam int SLOTS      = 32;
  localparam int ID_BITS    = 10;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCAN_BITS  = $clog2(SLOTS + 1);
  localparam int AMT_BITS   = 16;
  localparam int ALU_W      = ((COUNT_BITS > AMT_BITS) ? COUNT_BITS : AMT_BITS) + 1;

  typedef logic [ID_BITS-1:0]    id_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [SCAN_BITS-1:0]  scan_t;

  localparam cnt_t        COUNT_MAX = '1;
  localparam logic [15:0] EMPTY_QTY = 16'd64;

  // Request codes
  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_SUB    = 3'd1,
    REQ_QCOUNT = 3'd2,
    REQ_QSLOT  = 3'd3,
    REQ_READ   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NO_ITEM  = 2'd2,
    ST_NOT_ENUF = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC,
    S_OUT
  } state_t;

  // Channel payloads
  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  item_id;
    logic [15:0] amount;
    logic [4:0]  slot_sel;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [4:0]  slot_index;
    logic [9:0]  slot_item;
    logic [15:0] count;
  } out_rsp_t;

  // Table command and read data
  typedef struct packed {
    logic  wr_en;
    logic  clr;
    slot_t wr_addr;
    id_t   wr_id;
    cnt_t  wr_cnt;
    slot_t rd_addr;
  } tbl_cmd_t;

  typedef struct packed {
    id_t  id;
    cnt_t cnt;
  } tbl_data_t;

  // Shared arithmetic unit result
  typedef struct packed {
    cnt_t value;
    logic borrow;
  } alu_res_t;

endpackage

FILE: rtl/core/keyed_item_count_table.sv
// Top level of the keyed item count table: request sequencer, slot scan and
// result register. Depends on kict_pkg, kict_table and kict_alu.
//
// Usage: a request enters on in_valid/in_ready with an in_req_t payload and
// produces exactly one result on out_valid/out_ready as an out_rsp_t.
// in_ready is high only while the sequencer is idle; one request at a time.
// Add, subtract, query count and query slot scan all SLOTS slots through the
// single registered read port of the slot memory, one slot per cycle, then
// go to S_EXEC, where add and subtract use the shared count unit and write
// back when they succeed. Read slot reads its one slot in S_READ. Requests
// that need no scan or read (add or query count of id zero, subtract in
// creative mode, clear, unused codes, out-of-range read) go straight to S_OUT.
// in_ready returns the cycle after a result loads.
// The scan over the memory port sets the rate.
// A finished result waits in an output register; while the receiver stalls,
// the next request is accepted and worked, and only its hand-over waits.
// Reset empties every slot at once via valid bits and sets survival mode.
// cfg_we/cfg_wdata write survival_mode (1 survival, 0 creative); the user must
// write it only while idle, as the block does not enforce this.
module keyed_item_count_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kict_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kict_pkg::out_rsp_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import kict_pkg::*;

  state_t    state_r, state_nxt;
  in_req_t   req_r, req_nxt;
  out_rsp_t  rsp_r, rsp_nxt;
  out_rsp_t  out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      mode_r;

  scan_t     iss_r, iss_nxt;
  logic      chk_r, chk_nxt;
  slot_t     chk_idx_r, chk_idx_nxt;
  logic      m_hit_r, m_hit_nxt;
  slot_t     m_idx_r, m_idx_nxt;
  cnt_t      m_cnt_r, m_cnt_nxt;
  logic      e_hit_r, e_hit_nxt;
  slot_t     e_idx_r, e_idx_nxt;
  cnt_t      e_cnt_r, e_cnt_nxt;

  tbl_cmd_t  cmd;
  tbl_data_t rd_data;
  alu_res_t  alu_res;
  logic      alu_sub;
  cnt_t      alu_a;

  id_t       key;
  logic      use_m;
  slot_t     pick_idx;
  id_t       new_id;
  logic      accept;

  kict_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  kict_alu u_alu (
    .sub (alu_sub),
    .a   (alu_a),
    .b   (req_r.amount),
    .res (alu_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign key       = ID_BITS'(req_r.item_id);

  // Pick the slot for the count unit: add falls back to the last empty slot
  always_comb begin
    use_m    = m_hit_r || (req_r.req_type != REQ_ADD);
    pick_idx = use_m ? m_idx_r : e_idx_r;
    alu_a    = use_m ? m_cnt_r : e_cnt_r;
    alu_sub  = (req_r.req_type == REQ_SUB);
    new_id   = (alu_sub && (alu_res.value == '0)) ? '0 : key;
  end

  // Hold state, mode, search and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b1;
      chk_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chk_r       <= chk_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    rsp_r     <= rsp_nxt;
    out_r     <= out_nxt;
    iss_r     <= iss_nxt;
    chk_idx_r <= chk_idx_nxt;
    m_hit_r   <= m_hit_nxt;
    m_idx_r   <= m_idx_nxt;
    m_cnt_r   <= m_cnt_nxt;
    e_hit_r   <= e_hit_nxt;
    e_idx_r   <= e_idx_nxt;
    e_cnt_r   <= e_cnt_nxt;
  end

  // Sequence each request: decode, scan, execute, hand over
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rsp_nxt       = rsp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    iss_nxt       = iss_r;
    chk_nxt       = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    m_hit_nxt     = m_hit_r;
    m_idx_nxt     = m_idx_r;
    m_cnt_nxt     = m_cnt_r;
    e_hit_nxt     = e_hit_r;
    e_idx_nxt     = e_idx_r;
    e_cnt_nxt     = e_cnt_r;
    cmd           = '0;

    // Drop a result the receiver has taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_data;
          rsp_nxt   = '0;
          iss_nxt   = '0;
          m_hit_nxt = 1'b0;
          e_hit_nxt = 1'b0;
          state_nxt = S_OUT;
          case (in_data.req_type)
            REQ_ADD: begin
              if (in_data.item_id != '0) begin
                state_nxt = S_SCAN;
              end
            end
            REQ_SUB: begin
              if (mode_r) begin
                state_nxt = S_SCAN;
              end
            end
            REQ_QCOUNT: begin
              if (in_data.item_id == '0) begin
                rsp_nxt.count = EMPTY_QTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            REQ_QSLOT: begin
              state_nxt = S_SCAN;
            end
            REQ_READ: begin
              if (32'(in_data.slot_sel) < SLOTS) begin
                state_nxt = S_READ;
              end
            end
            REQ_CLEAR: begin
              cmd.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next slot read
        cmd.rd_addr = SLOT_BITS'(iss_r);
        if (32'(iss_r) < SLOTS) begin
          iss_nxt     = iss_r + 1'b1;
          chk_nxt     = 1'b1;
          chk_idx_nxt = SLOT_BITS'(iss_r);
        end else if (!chk_r) begin
          state_nxt = S_EXEC;
        end
        // Check the slot read last cycle
        if (chk_r) begin
          if (!m_hit_r && (rd_data.id == key)) begin
            m_hit_nxt = 1'b1;
            m_idx_nxt = chk_idx_r;
            m_cnt_nxt = rd_data.cnt;
          end
          if (rd_data.id == '0) begin
            e_hit_nxt = 1'b1;
            e_idx_nxt = chk_idx_r;
            e_cnt_nxt = rd_data.cnt;
          end
        end
      end

      S_READ: begin
        cmd.rd_addr = SLOT_BITS'(req_r.slot_sel);
        state_nxt   = S_EXEC;
      end

      S_EXEC: begin
        state_nxt = S_OUT;
        case (req_r.req_type)
          REQ_ADD: begin
            if (m_hit_r || e_hit_r) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_addr = pick_idx;
              cmd.wr_id   = key;
              cmd.wr_cnt  = alu_res.value;
              rsp_nxt     = '{ST_OK, 1'b1, 5'(pick_idx), 10'(key), 16'(alu_res.value)};
            end else begin
              rsp_nxt.status = ST_NO_FREE;
            end
          end
          REQ_SUB: begin
            if (!m_hit_r) begin
              rsp_nxt.status = ST_NO_ITEM;
            end else if (alu_res.borrow) begin
              rsp_nxt = '{ST_NOT_ENUF, 1'b1, 5'(m_idx_r), 10'(key), 16'(m_cnt_r)};
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_addr = m_idx_r;
              cmd.wr_id   = new_id;
              cmd.wr_cnt  = alu_res.value;
              rsp_nxt     = '{ST_OK, 1'b1, 5'(m_idx_r), 10'(new_id), 16'(alu_res.value)};
            end
          end
          REQ_QCOUNT: begin
            if (m_hit_r) begin
              rsp_nxt = '{ST_OK, 1'b1, 5'(m_idx_r), 10'(key), 16'(m_cnt_r)};
            end
          end
          REQ_QSLOT: begin
            if (m_hit_r) begin
              rsp_nxt = '{ST_OK, 1'b1, 5'(m_idx_r), 10'(key), 16'(m_cnt_r)};
            end else begin
              rsp_nxt.status = ST_NO_ITEM;
            end
          end
          REQ_READ: begin
            rsp_nxt = '{ST_OK, 1'b1, req_r.slot_sel, 10'(rd_data.id), 16'(rd_data.cnt)};
          end
          default: begin
          end
        endcase
      end

      S_OUT: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_nxt       = rsp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/kict_table.sv
// Slot memory of the keyed item count table: one write port, one registered
// read port, and per-slot valid bits that reset and clear wipe at once.
// Depends on kict_pkg.
module kict_table (
  input  logic                clk,
  input  logic                rst_n,
  input  kict_pkg::tbl_cmd_t  cmd,
  output kict_pkg::tbl_data_t rd_data
);
  import kict_pkg::*;

  tbl_data_t        mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  tbl_data_t        rd_data_r;
  logic             rd_vld_r;

  // Write and read the slot array
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= '{id: cmd.wr_id, cnt: cmd.wr_cnt};
    end
    rd_data_r <= mem[cmd.rd_addr];
  end

  // Track which slots hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        vld_r <= '0;
      end else if (cmd.wr_en) begin
        vld_r[cmd.wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[cmd.rd_addr];
    end
  end

  // Report a never-written slot as empty
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: rtl/core/kict_alu.sv
// Shared count unit: saturating add or borrow-checked subtract of a request
// amount against a slot count.
// Depends on kict_pkg.
module kict_alu (
  input  logic                       sub,
  input  kict_pkg::cnt_t             a,
  input  logic [kict_pkg::AMT_BITS-1:0] b,
  output kict_pkg::alu_res_t         res
);
  import kict_pkg::*;

  logic [ALU_W-1:0] sum;
  logic [ALU_W-1:0] diff;
  logic             sat;

  // One wide add and subtract
  always_comb begin
    sum  = ALU_W'(a) + ALU_W'(b);
    diff = ALU_W'(a) - ALU_W'(b);
    sat  = |sum[ALU_W-1:COUNT_BITS];
    if (sub) begin
      res.value  = COUNT_BITS'(diff);
      res.borrow = diff[ALU_W-1];
    end else begin
      res.value  = sat ? COUNT_MAX : COUNT_BITS'(sum);
      res.borrow = 1'b0;
    end
  end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for keyed_item_count_table: a shadow copy of the slot
// table predicts the responses that directed rows do not fix; all are compared
// field by field at hand-over. Depends on kict_pkg and keyed_item_count_table.
module testbench;
  import kict_pkg::*;

  localparam logic [2:0] REQ_UNUSED6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED7 = 3'd7;
  localparam int ID_POOL   = 40;
  localparam int HOLD_OFF  = 400;
  localparam int MAX_SHOWN = 10;
  localparam int DRAIN_CYC = 40;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } directed_req_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;

  // Shadow table and mode, updated as each request is accepted
  id_t      shadow_id [SLOTS];
  cnt_t     shadow_cnt [SLOTS];
  logic     shadow_survival = 1'b1;

  out_rsp_t      pending_rsp_q[$];
  directed_req_t directed_rows[$];
  int            mismatch_count = 0;
  int            burst_left = 0;
  bit            hold_off_req = 1'b0;

  keyed_item_count_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #20000000;
    $display("keyed_item_count_table: mismatch");
    $finish;
  end

  function automatic out_rsp_t mk_rsp(status_t st, logic fnd, int idx, id_t item, cnt_t cnt);
    out_rsp_t r;
    r.status     = st;
    r.found      = fnd;
    r.slot_index = 5'(idx);
    r.slot_item  = item;
    r.count      = cnt;
    return r;
  endfunction

  function automatic string fmt_rsp(out_rsp_t r);
    return $sformatf("status=%0d found=%0d slot=%0d item=%0d count=%0d",
                     r.status, r.found, r.slot_index, r.slot_item, r.count);
  endfunction

  // First slot holding key, or -1
  function automatic int first_slot(id_t key);
    int i;
    int s;
    s = -1;
    for (i = SLOTS - 1; i >= 0; i--) begin
      if (shadow_id[i] == key) s = i;
    end
    return s;
  endfunction

  // Apply one request to the shadow table and return the response it yields
  task automatic apply_to_shadow(input in_req_t r, output out_rsp_t rsp);
    int s;
    int i;
    bit hit;
    logic [ALU_W-1:0] sum;
    rsp = '0;
    case (r.req_type)
      REQ_ADD: begin
        if (r.item_id != '0) begin
          s = -1;
          hit = 1'b0;
          for (i = 0; i < SLOTS; i++) begin
            if (!hit) begin
              if (shadow_id[i] == r.item_id) begin
                s = i;
                hit = 1'b1;
              end else if (shadow_id[i] == '0) begin
                s = i;
              end
            end
          end
          if (s < 0) begin
            rsp = mk_rsp(ST_NO_FREE, 1'b0, 0, '0, '0);
          end else begin
            sum = ALU_W'(shadow_cnt[s]) + ALU_W'(r.amount);
            shadow_id[s]  = r.item_id;
            shadow_cnt[s] = (sum > ALU_W'(COUNT_MAX)) ? COUNT_MAX : cnt_t'(sum);
            rsp = mk_rsp(ST_OK, 1'b1, s, shadow_id[s], shadow_cnt[s]);
          end
        end
      end
      REQ_SUB: begin
        if (shadow_survival) begin
          s = first_slot(r.item_id);
          if (s < 0) begin
            rsp = mk_rsp(ST_NO_ITEM, 1'b0, 0, '0, '0);
          end else if (ALU_W'(r.amount) > ALU_W'(shadow_cnt[s])) begin
            rsp = mk_rsp(ST_NOT_ENUF, 1'b1, s, shadow_id[s], shadow_cnt[s]);
          end else begin
            shadow_cnt[s] = shadow_cnt[s] - cnt_t'(r.amount);
            if (shadow_cnt[s] == '0) shadow_id[s] = '0;
            rsp = mk_rsp(ST_OK, 1'b1, s, shadow_id[s], shadow_cnt[s]);
          end
        end
      end
      REQ_QCOUNT: begin
        if (r.item_id == '0) begin
          rsp = mk_rsp(ST_OK, 1'b0, 0, '0, cnt_t'(EMPTY_QTY));
        end else begin
          s = first_slot(r.item_id);
          if (s >= 0) rsp = mk_rsp(ST_OK, 1'b1, s, shadow_id[s], shadow_cnt[s]);
        end
      end
      REQ_QSLOT: begin
        s = first_slot(r.item_id);
        if (s < 0) rsp = mk_rsp(ST_NO_ITEM, 1'b0, 0, '0, '0);
        else rsp = mk_rsp(ST_OK, 1'b1, s, shadow_id[s], shadow_cnt[s]);
      end
      REQ_READ: begin
        s = int'(r.slot_sel);
        if (s < SLOTS) rsp = mk_rsp(ST_OK, 1'b1, s, shadow_id[s], shadow_cnt[s]);
      end
      REQ_CLEAR: begin
        for (i = 0; i < SLOTS; i++) begin
          shadow_id[i]  = '0;
          shadow_cnt[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_row(logic [2:0] rt, int id, int amt, int sel, bit typed, out_rsp_t rsp);
    directed_req_t row;
    row.req.req_type = rt;
    row.req.item_id  = 10'(id);
    row.req.amount   = 16'(amt);
    row.req.slot_sel = 5'(sel);
    row.typed = typed;
    row.rsp   = rsp;
    directed_rows.push_back(row);
  endtask

  // Offer one request in bursts with random gaps; hold it until accepted
  task automatic offer(in_req_t r, bit typed, out_rsp_t typed_rsp);
    out_rsp_t rsp;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    burst_left--;
    apply_to_shadow(r, rsp);
    if (typed) rsp = typed_rsp;
    pending_rsp_q.push_back(rsp);
  endtask

  // Wait for all responses, then write the mode register
  task automatic write_mode(logic mode);
    while (pending_rsp_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_survival = mode;
  endtask

  // Random request, mostly over a small id pool so the table fills and drains
  function automatic in_req_t gen_request();
    in_req_t r;
    int pick;
    int s;
    pick = $urandom_range(0, 999);
    if (pick < 400) r.req_type = REQ_ADD;
    else if (pick < 680) r.req_type = REQ_SUB;
    else if (pick < 770) r.req_type = REQ_QCOUNT;
    else if (pick < 850) r.req_type = REQ_QSLOT;
    else if (pick < 980) r.req_type = REQ_READ;
    else if (pick < 995) r.req_type = ($urandom_range(0, 1) != 0) ? REQ_UNUSED7 : REQ_UNUSED6;
    else r.req_type = REQ_CLEAR;
    pick = $urandom_range(0, 99);
    if (pick < 5) r.item_id = '0;
    else if (pick < 15) r.item_id = 10'($urandom_range(0, 1023));
    else r.item_id = 10'($urandom_range(1, ID_POOL));
    s = first_slot(r.item_id);
    case ($urandom_range(0, 9))
      0, 1, 2: r.amount = 16'($urandom_range(1, 20));
      3: r.amount = '0;
      4: r.amount = 16'($urandom_range(0, 65535));
      5: r.amount = 16'hFFFF;
      6: r.amount = (s >= 0) ? 16'(shadow_cnt[s]) : 16'($urandom_range(0, 20));
      7: r.amount = (s >= 0) ? 16'(shadow_cnt[s] + 1'b1) : 16'($urandom_range(0, 20));
      default: r.amount = 16'($urandom_range(0, 1000));
    endcase
    r.slot_sel = 5'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic run_random(int n_items);
    int i;
    for (i = 0; i < n_items; i++) offer(gen_request(), 1'b0, '0);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // Receiver: stall on changing patterns, plus one long hold-off on request
  initial begin : drive_out_ready
    int mode;
    int seg;
    int k;
    int i;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      k    = $urandom_range(2, 6);
      for (i = 0; i < seg; i++) begin
        @(posedge clk);
        if (hold_off_req && !hold_done) begin
          hold_done = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_OFF) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ((i % k) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare each handed-over response with the oldest prediction
  always @(posedge clk) begin : check_results
    out_rsp_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("unexpected response: %s", fmt_rsp(out_data));
        end
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_data.status !== want.status || out_data.found !== want.found ||
            out_data.slot_index !== want.slot_index ||
            out_data.slot_item !== want.slot_item || out_data.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("response mismatch: expected %s, got %s",
                     fmt_rsp(want), fmt_rsp(out_data));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    out_rsp_t none;
    none = '0;
    for (i = 0; i < SLOTS; i++) begin
      shadow_id[i]  = '0;
      shadow_cnt[i] = '0;
    end

    // Directed requests, run in survival mode straight out of reset
    add_row(REQ_READ,      0,     0,  0, 1, mk_rsp(ST_OK, 1'b1, 0, '0, '0));
    add_row(REQ_QCOUNT,    0,     0,  0, 1, mk_rsp(ST_OK, 1'b0, 0, '0, cnt_t'(EMPTY_QTY)));
    add_row(REQ_ADD,       0,     5,  0, 1, none);
    add_row(REQ_SUB,       5,     1,  0, 1, mk_rsp(ST_NO_ITEM, 1'b0, 0, '0, '0));
    add_row(REQ_SUB,       0,     0,  0, 1, mk_rsp(ST_OK, 1'b1, 0, '0, '0));
    add_row(REQ_SUB,       0,     1,  0, 1, mk_rsp(ST_NOT_ENUF, 1'b1, 0, '0, '0));
    add_row(REQ_QSLOT,     0,     0,  0, 1, mk_rsp(ST_OK, 1'b1, 0, '0, '0));
    add_row(REQ_ADD,    1023, 65535,  0, 1, mk_rsp(ST_OK, 1'b1, 31, 10'd1023, COUNT_MAX));
    add_row(REQ_ADD,    1023,     1,  0, 1, mk_rsp(ST_OK, 1'b1, 31, 10'd1023, COUNT_MAX));
    add_row(REQ_ADD,       1,     0, 31, 0, none);
    add_row(REQ_ADD,       1,   300,  0, 0, none);
    add_row(REQ_SUB,       1,   301,  0, 0, none);
    add_row(REQ_QCOUNT,    1,     0,  0, 0, none);
    add_row(REQ_QSLOT,  1023,     0,  0, 0, none);
    add_row(REQ_SUB,    1023, 65535,  0, 1, mk_rsp(ST_OK, 1'b1, 31, '0, '0));
    add_row(REQ_QCOUNT,   77,     0,  0, 1, none);
    add_row(REQ_QSLOT,    77,     0,  0, 1, mk_rsp(ST_NO_ITEM, 1'b0, 0, '0, '0));
    add_row(REQ_READ,      0,     0, 31, 0, none);
    add_row(REQ_SUB,       1,   300,  0, 0, none);
    add_row(REQ_ADD,       2, 65535,  0, 0, none);
    add_row(REQ_UNUSED6, 1023, 65535, 31, 1, none);
    add_row(REQ_UNUSED7, 1023, 65535, 31, 1, none);
    add_row(REQ_CLEAR,     0,     0,  0, 1, none);
    add_row(REQ_READ,      0,     0, 30, 0, none);
    add_row(REQ_QCOUNT,    2,     0,  0, 1, none);

    // Release reset, then walk the table
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[row_i]) begin
      offer(directed_rows[row_i].req, directed_rows[row_i].typed, directed_rows[row_i].rsp);
    end
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);

    // Random phases across both modes; the long receiver hold-off lands in the last
    write_mode(1'b0);
    run_random(300);
    write_mode(1'b1);
    run_random(800);
    write_mode(1'b0);
    run_random(100);
    write_mode(1'b1);
    hold_off_req = 1'b1;
    run_random(800);

    // Drain, then let the block settle
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("keyed_item_count_table: match");
    end else begin
      $display("keyed_item_count_table: mismatch");
    end
    $finish;
  end

endmodule
